@@ design/bgcd_pkg.sv @@
// Shared types for the binary greatest-common-divisor core.
// Holds the default width, the command sent along the cell row and the status fed back.
package bgcd_pkg;

	localparam int DataBitsDef = 63;

	// What every cell of the row does in a cycle
	typedef enum logic [2:0] {
		OP_HOLD       = 3'd0,
		OP_LOAD       = 3'd1,
		OP_SHIFT_BOTH = 3'd2,
		OP_SHIFT_A    = 3'd3,
		OP_SHIFT_B    = 3'd4,
		OP_REDUCE     = 3'd5,
		OP_SCALE      = 3'd6
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     swap;   // b < a: the smaller value moves into a
	} cell_cmd_t;

	typedef struct packed {
		logic a_lsb;
		logic b_lsb;
		logic a_zero;
		logic b_zero;
		logic borrow;     // borrow out of b - a, set when b < a
	} row_stat_t;

endpackage

@@ design/binary_gcd_core.sv @@
// Binary GCD core, top level: a row of bit cells under one sequencer.
// Depends on bgcd_pkg, bgcd_cell and bgcd_ctrl.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  in       | start & !busy          | operand_a, operand_b
//  out      | done (one-cycle pulse) | divisor
//
// An item ends after the load and the zero check when an operand is zero; otherwise
// the row shifts out the k shared trailing zeros, then the further zeros of a,
// then runs the reduce steps (one shift or halved subtract each) and scales back
// by k, with one-bit-per-cycle shifts through the cell row.
// Reset clears the sequencer and the result strobe; the cell bits are not reset.
// done pulses for one cycle and cannot be held off; a new item may start in that cycle.
module binary_gcd_core import bgcd_pkg::*; #(
	parameter int DATA_BITS = DataBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [DATA_BITS-1:0] operand_a,
	input  logic [DATA_BITS-1:0] operand_b,
	output logic                 done,
	output logic [DATA_BITS-1:0] divisor
);

	cell_cmd_t            cmd;
	row_stat_t            stat;
	logic                 fin;
	logic                 sel_b;
	logic [DATA_BITS-1:0] a_bits;
	logic [DATA_BITS-1:0] b_bits;
	logic [DATA_BITS-1:0] dba_bits;
	logic [DATA_BITS-1:0] dab_bits;
	logic [DATA_BITS:0]   br_ba;
	logic [DATA_BITS:0]   br_ab;
	logic [DATA_BITS:0]   a_hi;
	logic [DATA_BITS:0]   b_hi;
	logic [DATA_BITS:0]   dba_hi;
	logic [DATA_BITS:0]   dab_hi;
	logic [DATA_BITS:0]   a_lo;
	logic [DATA_BITS-1:0] divisor_q;
	logic                 done_q;

	// neighbour taps: a zero enters at the top on right shifts, at the bottom on left
	assign a_hi   = {1'b0, a_bits};
	assign b_hi   = {1'b0, b_bits};
	assign dba_hi = {1'b0, dba_bits};
	assign dab_hi = {1'b0, dab_bits};
	assign a_lo   = {a_bits, 1'b0};
	assign br_ba[0] = 1'b0;
	assign br_ab[0] = 1'b0;

	for (genvar i = 0; i < DATA_BITS; i++) begin : g_cell
		bgcd_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.ld_a      (operand_a[i]),
			.ld_b      (operand_b[i]),
			.a_up      (a_hi[i+1]),
			.b_up      (b_hi[i+1]),
			.a_dn      (a_lo[i]),
			.dba_up    (dba_hi[i+1]),
			.dab_up    (dab_hi[i+1]),
			.br_ba_in  (br_ba[i]),
			.br_ab_in  (br_ab[i]),
			.a_bit     (a_bits[i]),
			.b_bit     (b_bits[i]),
			.dba       (dba_bits[i]),
			.dab       (dab_bits[i]),
			.br_ba_out (br_ba[i+1]),
			.br_ab_out (br_ab[i+1])
		);
	end

	assign stat.a_lsb  = a_bits[0];
	assign stat.b_lsb  = b_bits[0];
	assign stat.a_zero = ~|a_bits;
	assign stat.b_zero = ~|b_bits;
	assign stat.borrow = br_ba[DATA_BITS];

	bgcd_ctrl #(
		.DATA_BITS (DATA_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.fin    (fin),
		.sel_b  (sel_b)
	);

	always_ff @(posedge clk) begin
		if (fin) begin
			divisor_q <= sel_b ? b_bits : a_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	assign done    = done_q;
	assign divisor = divisor_q;

endmodule

@@ design/bgcd_cell.sv @@
// One bit slice of the operand row: holds bit i of a and b.
// Depends on bgcd_pkg for the row command; among the cells it talks only to its two neighbours.
module bgcd_cell import bgcd_pkg::*; (
	input  logic      clk,
	input  cell_cmd_t cmd,
	input  logic      ld_a,
	input  logic      ld_b,
	input  logic      a_up,
	input  logic      b_up,
	input  logic      a_dn,
	input  logic      dba_up,
	input  logic      dab_up,
	input  logic      br_ba_in,
	input  logic      br_ab_in,
	output logic      a_bit,
	output logic      b_bit,
	output logic      dba,
	output logic      dab,
	output logic      br_ba_out,
	output logic      br_ab_out
);

	logic a_q;
	logic b_q;
	logic a_d;
	logic b_d;

	// b - a and a - b, one bit of each borrow chain
	assign dba       = b_q ^ a_q ^ br_ba_in;
	assign br_ba_out = (~b_q & a_q) | (~(b_q ^ a_q) & br_ba_in);
	assign dab       = a_q ^ b_q ^ br_ab_in;
	assign br_ab_out = (~a_q & b_q) | (~(a_q ^ b_q) & br_ab_in);

	always_comb begin
		a_d = a_q;
		b_d = b_q;
		unique case (cmd.op)
			OP_HOLD: begin
			end
			OP_LOAD: begin
				a_d = ld_a;
				b_d = ld_b;
			end
			OP_SHIFT_BOTH: begin
				a_d = a_up;
				b_d = b_up;
			end
			OP_SHIFT_A: begin
				a_d = a_up;
			end
			OP_SHIFT_B: begin
				b_d = b_up;
			end
			OP_REDUCE: begin
				// difference of two odd values is even: take it halved
				if (cmd.swap) begin
					a_d = b_q;
					b_d = dab_up;
				end else begin
					b_d = dba_up;
				end
			end
			OP_SCALE: begin
				a_d = a_dn;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		a_q <= a_d;
		b_q <= b_d;
	end

	assign a_bit = a_q;
	assign b_bit = b_q;

endmodule

@@ design/bgcd_ctrl.sv @@
// Sequencer for the binary GCD cell row: align, make a odd, reduce, scale back.
// Depends on bgcd_pkg; counts the shared power of two.
module bgcd_ctrl import bgcd_pkg::*; #(
	parameter int DATA_BITS = DataBitsDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  row_stat_t stat,
	output cell_cmd_t cmd,
	output logic      busy,
	output logic      fin,
	output logic      sel_b
);

	localparam int CntBits = $clog2(DATA_BITS);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CHECK  = 6'b000010,
		ST_ALIGN  = 6'b000100,
		ST_ODDA   = 6'b001000,
		ST_REDUCE = 6'b010000,
		ST_SCALE  = 6'b100000
	} state_t;

	state_t               state_q;
	state_t               state_d;
	logic [CntBits-1:0]   k_q;
	logic [CntBits-1:0]   k_d;

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		cmd.op   = OP_HOLD;
		cmd.swap = 1'b0;
		fin      = 1'b0;
		sel_b    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					k_d     = '0;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.a_zero || stat.b_zero) begin
					fin     = 1'b1;
					sel_b   = stat.a_zero;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (!stat.a_lsb && !stat.b_lsb) begin
					cmd.op = OP_SHIFT_BOTH;
					k_d    = k_q + CntBits'(1);
				end else begin
					state_d = ST_ODDA;
				end
			end
			ST_ODDA: begin
				if (stat.a_lsb) begin
					state_d = ST_REDUCE;
				end else begin
					cmd.op = OP_SHIFT_A;
				end
			end
			ST_REDUCE: begin
				if (stat.b_zero) begin
					state_d = ST_SCALE;
				end else if (!stat.b_lsb) begin
					cmd.op = OP_SHIFT_B;
				end else begin
					cmd.op   = OP_REDUCE;
					cmd.swap = stat.borrow;
				end
			end
			ST_SCALE: begin
				if (k_q == '0) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.op = OP_SCALE;
					k_d    = k_q - CntBits'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
